/* hdl/hkd_pkg.sv */
package hkd_pkg;

  localparam int KEY_SLOTS        = 6;
  localparam int INPUT_KEY_FIELDS = 6;
  // control changed, then a down and an up event for each slot
  localparam int NUM_EV           = 1 + 2 * KEY_SLOTS;
  // one more bit for the special combo event
  localparam int MASK_W           = NUM_EV + 1;
  localparam int COMBO_BIT        = NUM_EV;

  localparam logic [7:0] CODE_NONE     = 8'h00;
  localparam logic [7:0] CODE_ROLLOVER = 8'h01;
  localparam logic [7:0] CODE_CAPS     = 8'h39;
  localparam logic [7:0] CODE_V        = 8'h19;
  localparam logic [7:0] CODE_L        = 8'h0F;
  localparam logic [7:0] MASK_CTRL     = 8'h11;
  localparam logic [7:0] MASK_SHIFT    = 8'h22;

  typedef enum logic [1:0] {
    EV_CTRL  = 2'd0,
    EV_DOWN  = 2'd1,
    EV_UP    = 2'd2,
    EV_COMBO = 2'd3
  } event_kind_t;

  typedef logic [KEY_SLOTS-1:0][7:0] key_array_t;

  // what one slot lane found
  typedef struct packed {
    logic down;
    logic up;
  } lane_result_t;

  // one report's event run, handed to the serializer
  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [7:0]        combo_key;
    logic [7:0]        mods;
    logic [7:0]        old_mods;
    key_array_t        keys;
    key_array_t        prior_keys;
  } run_t;

endpackage

/* hdl/hkd_in_if.sv */
interface hkd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] modifiers;
  logic [7:0] key_a;
  logic [7:0] key_b;
  logic [7:0] key_c;
  logic [7:0] key_d;
  logic [7:0] key_e;
  logic [7:0] key_f;

  modport source (output valid, output modifiers, output key_a, output key_b,
                  output key_c, output key_d, output key_e, output key_f,
                  input ready);
  modport sink (input valid, input modifiers, input key_a, input key_b,
                input key_c, input key_d, input key_e, input key_f,
                output ready);
endinterface

/* hdl/hkd_out_if.sv */
interface hkd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_kind;
  logic [7:0] current_modifiers;
  logic [7:0] old_modifiers;
  logic [7:0] key_code;
  logic       last;

  modport source (output valid, output event_kind, output current_modifiers,
                  output old_modifiers, output key_code, output last,
                  input ready);
  modport sink (input valid, input event_kind, input current_modifiers,
                input old_modifiers, input key_code, input last,
                output ready);
endinterface

/* hdl/hkd_lane.sv */
module hkd_lane import hkd_pkg::*; (
  input  logic [7:0]   key,
  input  logic [7:0]   prior_key,
  input  key_array_t   keys,
  input  key_array_t   prior_keys,
  output lane_result_t result
);

  logic held;
  logic still;

  // compare this slot against every slot of the other report
  always_comb begin
    held  = 1'b0;
    still = 1'b0;
    for (int j = 0; j < KEY_SLOTS; j++) begin
      if (key == prior_keys[j] && key != CODE_ROLLOVER) held = 1'b1;
      if (keys[j] == prior_key && prior_key != CODE_ROLLOVER) still = 1'b1;
    end
  end

  // caps lock release is never reported
  assign result.down = !held;
  assign result.up   = !still && prior_key != CODE_CAPS;

endmodule

/* hdl/hkd_serializer.sv */
module hkd_serializer import hkd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic load,
  input  run_t run,
  output logic load_ready,
  hkd_out_if.source evt
);

  logic [MASK_W-1:0] mask;
  logic [MASK_W-1:0] mask_next;
  logic [MASK_W-1:0] low_bit;
  logic [MASK_W-1:0] rest;
  logic [7:0]        combo_key;
  logic [7:0]        mods;
  logic [7:0]        old_mods;
  key_array_t        keys;
  key_array_t        prior_keys;
  event_kind_t       sel_kind;
  logic [7:0]        sel_code;
  logic              take;

  // pending events, lowest bit goes first
  assign low_bit    = mask & (~mask + {{(MASK_W-1){1'b0}}, 1'b1});
  assign rest       = mask & ~low_bit;
  assign take       = evt.valid && evt.ready;
  assign load_ready = !evt.valid || (evt.ready && rest == '0);

  always_comb begin
    mask_next = mask;
    if (take) mask_next = rest;
    if (load) mask_next = run.mask;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else begin
      mask <= mask_next;
    end
  end

  // run payload
  always_ff @(posedge clk) begin
    if (load) begin
      combo_key  <= run.combo_key;
      mods       <= run.mods;
      old_mods   <= run.old_mods;
      keys       <= run.keys;
      prior_keys <= run.prior_keys;
    end
  end

  // pick the fields of the lowest pending event
  always_comb begin
    sel_kind = EV_CTRL;
    sel_code = CODE_NONE;
    if (mask[COMBO_BIT]) begin
      sel_kind = EV_COMBO;
      sel_code = combo_key;
    end
    for (int s = KEY_SLOTS - 1; s >= 0; s--) begin
      if (mask[2 + 2 * s]) begin
        sel_kind = EV_UP;
        sel_code = prior_keys[s];
      end
      if (mask[1 + 2 * s]) begin
        sel_kind = EV_DOWN;
        sel_code = keys[s];
      end
    end
    if (mask[0]) begin
      sel_kind = EV_CTRL;
      sel_code = CODE_NONE;
    end
  end

  assign evt.valid             = mask != '0;
  assign evt.event_kind        = sel_kind;
  assign evt.current_modifiers = mods;
  assign evt.old_modifiers     = (sel_kind == EV_CTRL) ? old_mods : 8'h00;
  assign evt.key_code          = sel_code;
  assign evt.last              = rest == '0;

  // a stalled event run keeps its pending set
  assert property (@(posedge clk) disable iff (rst)
    evt.valid && !evt.ready |=> $stable(mask))
    else $error("pending events changed during a stall");

  // a new run is only loaded when the old one is finishing
  assert property (@(posedge clk) disable iff (rst)
    load && evt.valid |-> evt.ready && evt.last)
    else $error("run loaded over pending events");

  // the last flag marks a single pending event
  assert property (@(posedge clk) disable iff (rst)
    evt.valid && evt.last |-> $onehot(mask))
    else $error("last flagged with more events pending");

  // the combo event always stands alone
  assert property (@(posedge clk) disable iff (rst)
    mask[COMBO_BIT] |-> $onehot(mask))
    else $error("combo event mixed with other events");

endmodule

/* hdl/hid_keyboard_report_differ.sv */
// channel  | modport | payload
// report   | sink    | modifiers, key_a .. key_f
// evt      | source  | event_kind, current_modifiers, old_modifiers, key_code, last
//
// a report is compared against the stored one by one lane per slot in the
// cycle it is accepted; its events then leave one per cycle, up to 13.
// the next report is taken in the cycle the previous run's last event is taken,
// or at once when no events are pending; a report with no events leaves none pending.
// synchronous reset clears the stored report and all pending events.
// a stall on evt holds the current event and blocks new reports.
module hid_keyboard_report_differ import hkd_pkg::*; (
  input  logic clk,
  input  logic rst,
  hkd_in_if.sink    report,
  hkd_out_if.source evt
);

  logic [7:0]                  prior_mods;
  key_array_t                  prior_keys;
  logic [INPUT_KEY_FIELDS-1:0][7:0] in_keys;
  key_array_t                  keys;
  lane_result_t [KEY_SLOTS-1:0] lanes;
  logic [KEY_SLOTS-1:0]        is_caps;
  logic [KEY_SLOTS-1:0]        is_vl;
  logic [7:0]                  vl_key;
  logic                        combo;
  logic                        accept;
  logic                        load_ready;
  run_t                        run;

  assign in_keys = {report.key_f, report.key_e, report.key_d,
                    report.key_c, report.key_b, report.key_a};

  // slots past the input fields read as no key
  always_comb begin
    for (int i = 0; i < KEY_SLOTS; i++) begin
      keys[i] = (i < INPUT_KEY_FIELDS) ? in_keys[i % INPUT_KEY_FIELDS] : CODE_NONE;
    end
  end

  // special combo detection
  always_comb begin
    vl_key = CODE_NONE;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      is_caps[i] = keys[i] == CODE_CAPS;
      is_vl[i]   = keys[i] == CODE_V || keys[i] == CODE_L;
      if (is_vl[i]) vl_key = keys[i];
    end
  end

  assign combo = $onehot(is_vl) && (is_caps != '0) &&
                 ((report.modifiers & MASK_CTRL) != 8'h00) &&
                 ((report.modifiers & MASK_SHIFT) != 8'h00);

  // one lane per slot
  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    hkd_lane u_lane (
      .key        (keys[g]),
      .prior_key  (prior_keys[g]),
      .keys       (keys),
      .prior_keys (prior_keys),
      .result     (lanes[g])
    );
  end

  // merge lane results into the event run
  always_comb begin
    run.mask = '0;
    if (combo) begin
      run.mask[COMBO_BIT] = 1'b1;
    end else begin
      run.mask[0] = report.modifiers != prior_mods;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        run.mask[1 + 2 * i] = lanes[i].down;
        run.mask[2 + 2 * i] = lanes[i].up;
      end
    end
    run.combo_key  = vl_key;
    run.mods       = report.modifiers;
    run.old_mods   = prior_mods;
    run.keys       = keys;
    run.prior_keys = prior_keys;
  end

  assign report.ready = load_ready;
  assign accept       = report.valid && report.ready;

  // stored report, left alone by a special combo
  always_ff @(posedge clk) begin
    if (rst) begin
      prior_mods <= 8'h00;
      prior_keys <= '0;
    end else if (accept && !combo) begin
      prior_mods <= report.modifiers;
      prior_keys <= keys;
    end
  end

  hkd_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .load       (accept),
    .run        (run),
    .load_ready (load_ready),
    .evt        (evt)
  );

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import hkd_pkg::*;

  localparam int DIRECTED_LIMIT = 25;
  localparam int RANDOM_REPORTS = 349;
  localparam int IDLE_PCT       = 21;
  localparam int CALM_FROM      = 150;
  localparam int CALM_TO        = 230;
  localparam int SETTLE_CYCLES  = 24;
  localparam int CYCLE_LIMIT    = 200000;

  typedef struct {
    logic [7:0] mods;
    key_array_t keys;
    bit         drain;
  } kbd_report_t;

  typedef struct {
    event_kind_t kind;
    logic [7:0]  cur_mods;
    logic [7:0]  old_mods;
    logic [7:0]  code;
    logic        last;
  } key_event_t;

  logic clk;
  logic rst;

  hkd_in_if  report_bus ();
  hkd_out_if evt_bus ();

  hid_keyboard_report_differ uut (
    .clk    (clk),
    .rst    (rst),
    .report (report_bus),
    .evt    (evt_bus)
  );

  // reports waiting to be sent, and events the block owes us
  kbd_report_t pending_reports[$];
  key_event_t  expected_events[$];
  kbd_report_t offered;

  // copy of the report the block holds
  logic [7:0] held_mods;
  key_array_t held_keys;

  int reports_taken;
  int events_checked;
  int combos_seen;
  int silent_reports;
  int error_count;
  int cycle_count;

  // clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // work out the event run one report causes and update the held report
  function automatic void predict_events(input logic [7:0] mods, input key_array_t keys);
    int         vl_count;
    logic [7:0] vl_key;
    bit         caps;
    bit         held;
    bit         still;
    key_event_t ev;
    key_event_t run[$];

    vl_count = 0;
    vl_key   = CODE_NONE;
    caps     = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (keys[i] == CODE_CAPS) caps = 1'b1;
      if (keys[i] == CODE_V || keys[i] == CODE_L) begin
        vl_count++;
        vl_key = keys[i];
      end
    end

    // special combo: one event, held report untouched
    if (vl_count == 1 && caps && (mods & MASK_CTRL) != 8'h00 &&
        (mods & MASK_SHIFT) != 8'h00) begin
      ev.kind     = EV_COMBO;
      ev.cur_mods = mods;
      ev.old_mods = 8'h00;
      ev.code     = vl_key;
      ev.last     = 1'b1;
      expected_events.push_back(ev);
      return;
    end

    if (mods != held_mods) begin
      ev.kind     = EV_CTRL;
      ev.cur_mods = mods;
      ev.old_mods = held_mods;
      ev.code     = 8'h00;
      ev.last     = 1'b0;
      run.push_back(ev);
    end

    // per slot: key down, then key up
    for (int i = 0; i < KEY_SLOTS; i++) begin
      held  = 1'b0;
      still = 1'b0;
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (keys[i] == held_keys[j] && keys[i] != CODE_ROLLOVER) held = 1'b1;
        if (keys[j] == held_keys[i] && held_keys[i] != CODE_ROLLOVER) still = 1'b1;
      end
      if (!held) begin
        ev.kind     = EV_DOWN;
        ev.cur_mods = mods;
        ev.old_mods = 8'h00;
        ev.code     = keys[i];
        ev.last     = 1'b0;
        run.push_back(ev);
      end
      // caps lock release is swallowed
      if (!still && held_keys[i] != CODE_CAPS) begin
        ev.kind     = EV_UP;
        ev.cur_mods = mods;
        ev.old_mods = 8'h00;
        ev.code     = held_keys[i];
        ev.last     = 1'b0;
        run.push_back(ev);
      end
    end

    held_mods = mods;
    held_keys = keys;

    if (run.size() == 0) begin
      silent_reports++;
    end else begin
      run[run.size()-1].last = 1'b1;
      foreach (run[k]) expected_events.push_back(run[k]);
    end
  endfunction

  // codes drawn from a small pool so that slots often match
  function automatic logic [7:0] pick_code();
    logic [7:0] code;
    case ($urandom_range(9))
      0:       code = CODE_NONE;
      1:       code = CODE_ROLLOVER;
      2:       code = CODE_CAPS;
      3:       code = CODE_V;
      4:       code = CODE_L;
      9:       code = 8'($urandom_range(255));
      default: code = 8'(8'h04 + $urandom_range(7));
    endcase
    return code;
  endfunction

  // typing: a few keys pressed or released, sometimes a modifier
  function automatic kbd_report_t evolve_report(input kbd_report_t prev);
    kbd_report_t r;
    int          flip;
    r       = prev;
    r.drain = 1'b0;
    if ($urandom_range(3) == 0) begin
      flip         = $urandom_range(7);
      r.mods[flip] = ~r.mods[flip];
    end
    repeat ($urandom_range(2)) r.keys[$urandom_range(KEY_SLOTS-1)] = pick_code();
    return r;
  endfunction

  // caps lock plus ctrl, shift and V or L, now and then broken
  function automatic kbd_report_t combo_report(input kbd_report_t prev);
    kbd_report_t r;
    int          caps_slot;
    int          key_slot;
    r         = evolve_report(prev);
    caps_slot = $urandom_range(KEY_SLOTS-1);
    key_slot  = (caps_slot + 1 + $urandom_range(KEY_SLOTS-2)) % KEY_SLOTS;
    r.mods    = 8'($urandom_range(255));
    r.mods   |= MASK_CTRL & ($urandom_range(1) ? 8'h0F : 8'hF0);
    r.mods   |= MASK_SHIFT & ($urandom_range(1) ? 8'h0F : 8'hF0);
    r.keys[caps_slot] = CODE_CAPS;
    r.keys[key_slot]  = $urandom_range(1) ? CODE_V : CODE_L;
    case ($urandom_range(7))
      0: r.mods &= ~MASK_SHIFT;
      1: r.mods &= ~MASK_CTRL;
      2: r.keys[caps_slot] = pick_code();
      default: ;
    endcase
    return r;
  endfunction

  task automatic add_report(input logic [7:0] m, input logic [7:0] a, input logic [7:0] b,
                            input logic [7:0] c, input logic [7:0] d, input logic [7:0] e,
                            input logic [7:0] f);
    kbd_report_t r;
    r.mods    = m;
    r.keys[0] = a;
    r.keys[1] = b;
    r.keys[2] = c;
    r.keys[3] = d;
    r.keys[4] = e;
    r.keys[5] = f;
    r.drain   = 1'b0;
    pending_reports.push_back(r);
  endtask

  // sender: offers the next report once the last one is taken
  always @(posedge clk) begin
    int idle_pct;
    if (rst) begin
      report_bus.valid <= 1'b0;
    end else begin
      if (report_bus.valid && report_bus.ready) begin
        predict_events(offered.mods, offered.keys);
        reports_taken++;
      end
      idle_pct = (reports_taken >= CALM_FROM && reports_taken < CALM_TO) ? 0 : IDLE_PCT;
      if (!report_bus.valid || report_bus.ready) begin
        if (pending_reports.size() != 0 &&
            !(pending_reports[0].drain && expected_events.size() != 0) &&
            $urandom_range(99) >= idle_pct) begin
          offered = pending_reports.pop_front();
          report_bus.valid     <= 1'b1;
          report_bus.modifiers <= offered.mods;
          report_bus.key_a     <= offered.keys[0];
          report_bus.key_b     <= offered.keys[1];
          report_bus.key_c     <= offered.keys[2];
          report_bus.key_d     <= offered.keys[3];
          report_bus.key_e     <= offered.keys[4];
          report_bus.key_f     <= offered.keys[5];
        end else begin
          report_bus.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each event transaction against the oldest expectation
  always @(posedge clk) begin
    key_event_t exp_ev;
    int         idle_pct;
    if (rst) begin
      evt_bus.ready <= 1'b0;
    end else begin
      if (evt_bus.valid && evt_bus.ready) begin
        if (evt_bus.event_kind == EV_COMBO) combos_seen++;
        if (expected_events.size() == 0) begin
          $error("event with none expected: event_kind %0d key_code %0h",
                 evt_bus.event_kind, evt_bus.key_code);
          error_count++;
        end else begin
          exp_ev = expected_events.pop_front();
          events_checked++;
          if (evt_bus.event_kind !== exp_ev.kind) begin
            $error("event_kind: expected %0d, got %0d", exp_ev.kind, evt_bus.event_kind);
            error_count++;
          end
          if (evt_bus.current_modifiers !== exp_ev.cur_mods) begin
            $error("current_modifiers: expected %0h, got %0h", exp_ev.cur_mods,
                   evt_bus.current_modifiers);
            error_count++;
          end
          if (evt_bus.old_modifiers !== exp_ev.old_mods) begin
            $error("old_modifiers: expected %0h, got %0h", exp_ev.old_mods,
                   evt_bus.old_modifiers);
            error_count++;
          end
          if (evt_bus.key_code !== exp_ev.code) begin
            $error("key_code: expected %0h, got %0h", exp_ev.code, evt_bus.key_code);
            error_count++;
          end
          if (evt_bus.last !== exp_ev.last) begin
            $error("last: expected %0d, got %0d", exp_ev.last, evt_bus.last);
            error_count++;
          end
        end
      end
      idle_pct = (reports_taken >= CALM_FROM && reports_taken < CALM_TO) ? 0 : IDLE_PCT;
      evt_bus.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("hid_keyboard_report_differ test failed");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    kbd_report_t gen;
    int          roll;

    rst                  = 1'b1;
    report_bus.valid     = 1'b0;
    report_bus.modifiers = 8'h00;
    report_bus.key_a     = 8'h00;
    report_bus.key_b     = 8'h00;
    report_bus.key_c     = 8'h00;
    report_bus.key_d     = 8'h00;
    report_bus.key_e     = 8'h00;
    report_bus.key_f     = 8'h00;
    evt_bus.ready        = 1'b0;
    held_mods            = 8'h00;
    held_keys            = '0;
    reports_taken        = 0;
    events_checked       = 0;
    combos_seen          = 0;
    silent_reports       = 0;
    error_count          = 0;
    cycle_count          = 0;

    // directed: unchanged report, full runs, rollover, caps lock, combos
    add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    add_report(8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
    add_report(8'hFF, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
    add_report(8'hFF, 8'h00, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
    add_report(8'h00, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01);
    add_report(8'hAA, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01, 8'h01);
    add_report(8'h55, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00);
    add_report(8'h00, 8'h39, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    add_report(8'h03, 8'h39, 8'h19, 8'h00, 8'h00, 8'h00, 8'h00);
    add_report(8'h30, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h39);
    add_report(8'hFF, 8'h2A, 8'h39, 8'h00, 8'h0F, 8'hFE, 8'h01);
    add_report(8'h33, 8'h39, 8'h19, 8'h0F, 8'h00, 8'h00, 8'h00);
    add_report(8'h11, 8'h39, 8'h19, 8'h19, 8'h00, 8'h00, 8'h00);
    add_report(8'h01, 8'h39, 8'h19, 8'h00, 8'h00, 8'h00, 8'h00);
    add_report(8'h03, 8'h00, 8'h19, 8'h00, 8'h00, 8'h00, 8'h00);
    add_report(8'h02, 8'h39, 8'h0F, 8'h00, 8'h00, 8'h00, 8'h00);
    add_report(8'h80, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09);
    add_report(8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    add_report(8'h7F, 8'h39, 8'h39, 8'h04, 8'h04, 8'h01, 8'h00);
    add_report(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    assert (pending_reports.size() <= DIRECTED_LIMIT);

    // random: mostly typing, some combo attempts, some raw noise
    gen = pending_reports[pending_reports.size()-1];
    for (int k = 0; k < RANDOM_REPORTS; k++) begin
      roll = $urandom_range(99);
      if (roll < 60) begin
        gen = evolve_report(gen);
      end else if (roll < 75) begin
        gen = combo_report(gen);
      end else if (roll < 90) begin
        gen.mods = 8'($urandom_range(255));
        for (int s = 0; s < KEY_SLOTS; s++) gen.keys[s] = 8'($urandom_range(255));
      end
      // first random report waits for the directed events to drain
      gen.drain = (k == 0) || ($urandom_range(99) < 2);
      pending_reports.push_back(gen);
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (pending_reports.size() != 0 || report_bus.valid || expected_events.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("sent %0d reports (%0d with no events), checked %0d events, %0d special combos",
             reports_taken, silent_reports, events_checked, combos_seen);
    if (error_count == 0 && expected_events.size() == 0) begin
      $display("hid_keyboard_report_differ test passed");
    end else begin
      $display("hid_keyboard_report_differ test failed");
    end
    $finish;
  end

endmodule
